FILE: design/octave_gradient_noise_2d_defines.svh
// Assertion macros used by the checker file.
`ifndef OCTAVE_GRADIENT_NOISE_2D_DEFINES_SVH
`define OCTAVE_GRADIENT_NOISE_2D_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define OGN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define OGN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: design/ogn_pkg.sv
`default_nettype none
package ogn_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_OCTAVES_DEF = 8;
	localparam int FRAC_BITS_DEF   = 16;

	// Permutation table geometry
	localparam int TABLE_DEPTH = 512;
	localparam int TABLE_AW    = 9;
	localparam int TABLE_DW    = 8;

	// Amplitude: unsigned Q18.14
	localparam int AMP_W    = 32;
	localparam int AMP_FRAC = 14;
	localparam int PERS_W   = 16;
	localparam int OCNT_W   = 4;

	// Result: signed Q2.14, quotient magnitude bits before saturation
	localparam int OUT_W  = 16;
	localparam int QUOT_W = 17;

	// Configuration register indexes
	localparam logic CFG_OCTAVE_COUNT = 1'b0;
	localparam logic CFG_PERSISTENCE  = 1'b1;

	localparam logic [OCNT_W-1:0] OCTAVE_COUNT_RST = 4'd1;
	localparam logic [PERS_W-1:0] PERSISTENCE_RST  = 16'd16384;

	// Command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_EVAL  = 1'b1;

	// Gradient selection from the low two hash bits
	localparam logic [1:0] GRAD_X    = 2'd0;
	localparam logic [1:0] GRAD_XY   = 2'd1;
	localparam logic [1:0] GRAD_Y    = 2'd2;
	localparam logic [1:0] GRAD_YMX  = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD0,
		S_RD1,
		S_RD2,
		S_RD3,
		S_LY0,
		S_LY1,
		S_LX,
		S_ACC,
		S_DIV0,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

endpackage
`default_nettype wire

FILE: design/octave_gradient_noise_2d.sv
// Channel   Handshake                Payload
// command   start / busy             cmd, table_index, table_value, x_coord, y_coord
// result    done (one-cycle strobe)  noise_value
// config    cfg_we                   cfg_index, cfg_data
//
// A table write leaves busy low.
// An evaluation keeps busy high through n octaves (n = clamped octave count), each a
// chain of dependent table reads through the one synchronous table, then the divider
// load, the bit-serial normalizing divide, saturation and presenting the result.
// done is high for one cycle in the last busy cycle; the receiver cannot stall.
// Reset clears control and the two config registers; the table is unknown until written.
`default_nettype none
module octave_gradient_noise_2d #(
	parameter int MAX_OCTAVES = ogn_pkg::MAX_OCTAVES_DEF,
	parameter int FRAC_BITS   = ogn_pkg::FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic                             cmd,
	input  wire logic [ogn_pkg::TABLE_AW-1:0]     table_index,
	input  wire logic [ogn_pkg::TABLE_DW-1:0]     table_value,
	input  wire logic signed [31:0]               x_coord,
	input  wire logic signed [31:0]               y_coord,
	output logic                                  done,
	output logic signed [ogn_pkg::OUT_W-1:0]      noise_value,
	input  wire logic                             cfg_we,
	input  wire logic                             cfg_index,
	input  wire logic [ogn_pkg::PERS_W-1:0]       cfg_data
);

	localparam int F        = FRAC_BITS;
	localparam int CW       = F + 2;
	localparam int OCT_W    = $clog2(MAX_OCTAVES + 1);
	localparam int PROD_W   = CW + ogn_pkg::AMP_W + 1;
	localparam int TOT_W    = PROD_W + OCT_W;
	localparam int ASUM_W   = ogn_pkg::AMP_W + OCT_W;
	localparam int SH_UP    = (F < ogn_pkg::AMP_FRAC) ? ogn_pkg::AMP_FRAC - F : 0;
	localparam int SH_DN    = (F > ogn_pkg::AMP_FRAC) ? F - ogn_pkg::AMP_FRAC : 0;
	localparam int NUM_W    = TOT_W + SH_UP;
	localparam int DEN_W    = ASUM_W + SH_DN;
	localparam int DIV_W    = (NUM_W > DEN_W + ogn_pkg::QUOT_W) ? NUM_W
		: DEN_W + ogn_pkg::QUOT_W;

	// Blend a toward b by weight t (Q.F), floored
	function automatic logic signed [CW-1:0] lerp(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b, input logic [F:0] t);
		logic signed [CW:0]     d;
		logic signed [CW+F+2:0] p;
		logic [CW+2:0]          s;
		d = {b[CW-1], b} - {a[CW-1], a};
		p = d * $signed({1'b0, t});
		s = p[CW+F+2:F] + {{3{a[CW-1]}}, a};
		return s[CW-1:0];
	endfunction

	// Dot product of the gradient picked by the hash with the offset
	function automatic logic signed [CW-1:0] corner(input logic [1:0] h,
		input logic signed [CW-1:0] dx, input logic signed [CW-1:0] dy);
		logic signed [CW-1:0] r;
		case (h)
			ogn_pkg::GRAD_X:   r = dx;
			ogn_pkg::GRAD_XY:  r = dx + dy;
			ogn_pkg::GRAD_Y:   r = dy;
			ogn_pkg::GRAD_YMX: r = dy - dx;
			default:           r = dx;
		endcase
		return r;
	endfunction

	ogn_pkg::state_t state_q, state_nx;

	logic [ogn_pkg::OCNT_W-1:0] octave_count_q;
	logic [ogn_pkg::PERS_W-1:0] persistence_q;

	logic [31:0]                sx_q, sy_q;
	logic [OCT_W-1:0]           oct_q, n_q;
	logic [ogn_pkg::AMP_W-1:0]  amp_q;
	logic [ogn_pkg::AMP_W-1:0]  amp_cur_q;
	logic signed [TOT_W-1:0]    total_q;
	logic [ASUM_W-1:0]          asum_q;
	logic [F-1:0]               ff_q;
	logic [F:0]                 u_q, v_q;
	logic [ogn_pkg::TABLE_DW-1:0] px0_q, px1_q, hbl_q, hbr_q, htl_q, htr_q;
	logic signed [CW-1:0]       left_q, right_q, nv_q;
	logic [DIV_W-1:0]           rem_q, dsh_q;
	logic [ogn_pkg::QUOT_W-1:0] quot_q;
	logic [4:0]                 cnt_q;
	logic                       neg_q, sat_q;
	logic signed [ogn_pkg::OUT_W-1:0] res_q;

	logic accept;
	logic [ogn_pkg::TABLE_AW-1:0] raddr_a, raddr_b;
	logic [ogn_pkg::TABLE_DW-1:0] rdata_a, rdata_b;
	logic [F-1:0]   fx, fy, fsel;
	logic [7:0]     cx, cy;
	logic [2*F-1:0] sq;
	logic [F+1:0]   wgt;
	logic [2*F+1:0] fprod;
	logic signed [CW-1:0] dx0, dx1, dy0, dy1;
	logic [4:0]     n_clamp;
	logic           last_oct;
	logic [ogn_pkg::AMP_W+ogn_pkg::PERS_W-1:0] amp_prod;
	logic [TOT_W-1:0] tot_mag;
	logic [DIV_W-1:0] num, den;
	logic             ge;

	assign accept = start && !busy;

	// Lattice cell and fraction of the current octave
	assign cx = sx_q[F+7:F];
	assign cy = sy_q[F+7:F];
	assign fx = sx_q[F-1:0];
	assign fy = sy_q[F-1:0];

	// Corner offsets
	assign dx0 = {2'b00, fx};
	assign dx1 = {2'b00, fx} - {2'b01, {F{1'b0}}};
	assign dy0 = {2'b00, fy};
	assign dy1 = {2'b00, fy} - {2'b01, {F{1'b0}}};

	// Shared fade path: square in one state, cubic weight in the next
	assign fsel  = (state_q == ogn_pkg::S_RD0 || state_q == ogn_pkg::S_RD1) ? fx : fy;
	assign sq    = {{F{1'b0}}, fsel} * {{F{1'b0}}, fsel};
	assign wgt   = {2'b11, {F{1'b0}}} - {1'b0, fsel, 1'b0};
	assign fprod = {{(F+2){1'b0}}, ff_q} * {{F{1'b0}}, wgt};

	assign n_clamp = (octave_count_q == '0) ? 5'd1
		: ({1'b0, octave_count_q} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
		: {1'b0, octave_count_q};
	assign last_oct = (oct_q + OCT_W'(1)) == n_q;

	assign amp_prod = {{ogn_pkg::PERS_W{1'b0}}, amp_q}
		* {{ogn_pkg::AMP_W{1'b0}}, persistence_q};

	// Divider operands, rescaled so the quotient is Q.14
	assign tot_mag = total_q[TOT_W-1] ? TOT_W'(-total_q) : TOT_W'(total_q);
	assign num     = DIV_W'({tot_mag, {SH_UP{1'b0}}} );
	assign den     = DIV_W'({asum_q, {SH_DN{1'b0}}});
	assign ge      = rem_q >= dsh_q;

	// Table address selection per read step
	always_comb begin
		raddr_a = {1'b0, cx};
		raddr_b = {1'b0, cx} + 9'd1;
		case (state_q)
			ogn_pkg::S_RD1: begin
				raddr_a = {1'b0, rdata_a} + {1'b0, cy};
				raddr_b = {1'b0, rdata_b} + {1'b0, cy};
			end
			ogn_pkg::S_RD2: begin
				raddr_a = {1'b0, px0_q} + {1'b0, cy} + 9'd1;
				raddr_b = {1'b0, px1_q} + {1'b0, cy} + 9'd1;
			end
			default: begin
				raddr_a = {1'b0, cx};
				raddr_b = {1'b0, cx} + 9'd1;
			end
		endcase
	end

	ogn_perm_ram u_ram (
		.clk     (clk),
		.we      (accept && cmd == ogn_pkg::CMD_WRITE),
		.waddr   (table_index),
		.wdata   (table_value),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ogn_pkg::S_IDLE: begin
				if (accept && cmd == ogn_pkg::CMD_EVAL) begin
					state_nx = ogn_pkg::S_RD0;
				end
			end
			ogn_pkg::S_RD0: state_nx = ogn_pkg::S_RD1;
			ogn_pkg::S_RD1: state_nx = ogn_pkg::S_RD2;
			ogn_pkg::S_RD2: state_nx = ogn_pkg::S_RD3;
			ogn_pkg::S_RD3: state_nx = ogn_pkg::S_LY0;
			ogn_pkg::S_LY0: state_nx = ogn_pkg::S_LY1;
			ogn_pkg::S_LY1: state_nx = ogn_pkg::S_LX;
			ogn_pkg::S_LX:  state_nx = ogn_pkg::S_ACC;
			ogn_pkg::S_ACC: state_nx = last_oct ? ogn_pkg::S_DIV0 : ogn_pkg::S_RD0;
			ogn_pkg::S_DIV0: state_nx = ogn_pkg::S_DIV;
			ogn_pkg::S_DIV: begin
				if (cnt_q == 5'd0) begin
					state_nx = ogn_pkg::S_FIN;
				end
			end
			ogn_pkg::S_FIN: state_nx = ogn_pkg::S_OUT;
			ogn_pkg::S_OUT: state_nx = ogn_pkg::S_IDLE;
			default:        state_nx = ogn_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		busy        = (state_q != ogn_pkg::S_IDLE);
		done        = (state_q == ogn_pkg::S_OUT);
		noise_value = res_q;
	end

	// Control state and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ogn_pkg::S_IDLE;
			octave_count_q <= ogn_pkg::OCTAVE_COUNT_RST;
			persistence_q  <= ogn_pkg::PERSISTENCE_RST;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				case (cfg_index)
					ogn_pkg::CFG_OCTAVE_COUNT: octave_count_q <= cfg_data[ogn_pkg::OCNT_W-1:0];
					ogn_pkg::CFG_PERSISTENCE:  persistence_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ogn_pkg::S_IDLE: begin
				sx_q    <= x_coord;
				sy_q    <= y_coord;
				oct_q   <= '0;
				n_q     <= OCT_W'(n_clamp);
				amp_q   <= ogn_pkg::AMP_W'(1 << ogn_pkg::AMP_FRAC);
				total_q <= '0;
				asum_q  <= '0;
			end
			ogn_pkg::S_RD0: ff_q <= sq[2*F-1:F];
			ogn_pkg::S_RD1: begin
				u_q   <= fprod[2*F:F];
				px0_q <= rdata_a;
				px1_q <= rdata_b;
			end
			ogn_pkg::S_RD2: begin
				ff_q  <= sq[2*F-1:F];
				hbl_q <= rdata_a;
				hbr_q <= rdata_b;
			end
			ogn_pkg::S_RD3: begin
				v_q   <= fprod[2*F:F];
				htl_q <= rdata_a;
				htr_q <= rdata_b;
			end
			ogn_pkg::S_LY0: begin
				left_q <= lerp(corner(hbl_q[1:0], dx0, dy0), corner(htl_q[1:0], dx0, dy1), v_q);
				// next amplitude, saturated
				if (|amp_prod[ogn_pkg::AMP_W+ogn_pkg::PERS_W-1:ogn_pkg::AMP_W+ogn_pkg::AMP_FRAC]) begin
					amp_q <= '1;
				end else begin
					amp_q <= amp_prod[ogn_pkg::AMP_W+ogn_pkg::AMP_FRAC-1:ogn_pkg::AMP_FRAC];
				end
				asum_q <= asum_q + ASUM_W'(amp_q);
				nv_q   <= '0;
			end
			ogn_pkg::S_LY1: begin
				right_q <= lerp(corner(hbr_q[1:0], dx1, dy0), corner(htr_q[1:0], dx1, dy1), v_q);
			end
			ogn_pkg::S_LX: nv_q <= lerp(left_q, right_q, u_q);
			ogn_pkg::S_ACC: begin
				// amp_q now holds the next amplitude; weight by the current one
				total_q <= total_q + TOT_W'($signed(PROD_W'(
					nv_q * $signed({1'b0, amp_cur_q}))));
				sx_q  <= {sx_q[30:0], 1'b0};
				sy_q  <= {sy_q[30:0], 1'b0};
				oct_q <= oct_q + OCT_W'(1);
			end
			ogn_pkg::S_DIV0: begin
				neg_q  <= total_q[TOT_W-1];
				sat_q  <= num >= (den << ogn_pkg::QUOT_W);
				rem_q  <= num;
				dsh_q  <= den << (ogn_pkg::QUOT_W - 1);
				cnt_q  <= 5'(ogn_pkg::QUOT_W - 1);
				quot_q <= '0;
			end
			ogn_pkg::S_DIV: begin
				if (ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quot_q <= {quot_q[ogn_pkg::QUOT_W-2:0], ge};
				dsh_q  <= dsh_q >> 1;
				cnt_q  <= cnt_q - 5'd1;
			end
			ogn_pkg::S_FIN: begin
				if (neg_q) begin
					if (sat_q || quot_q > 17'd32768) begin
						res_q <= 16'sh8000;
					end else begin
						res_q <= ogn_pkg::OUT_W'(-$signed({1'b0, quot_q}));
					end
				end else begin
					if (sat_q || quot_q > 17'd32767) begin
						res_q <= 16'sh7FFF;
					end else begin
						res_q <= quot_q[ogn_pkg::OUT_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	// Amplitude of the octave in flight, captured before the update
	always_ff @(posedge clk) begin
		if (state_q == ogn_pkg::S_LY0) begin
			amp_cur_q <= amp_q;
		end
	end

endmodule
`default_nettype wire

FILE: design/ogn_perm_ram.sv
`default_nettype none
// Permutation table: one write port, two registered read ports
module ogn_perm_ram (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [ogn_pkg::TABLE_AW-1:0] waddr,
	input  wire logic [ogn_pkg::TABLE_DW-1:0] wdata,
	input  wire logic [ogn_pkg::TABLE_AW-1:0] raddr_a,
	input  wire logic [ogn_pkg::TABLE_AW-1:0] raddr_b,
	output logic      [ogn_pkg::TABLE_DW-1:0] rdata_a,
	output logic      [ogn_pkg::TABLE_DW-1:0] rdata_b
);

	logic [ogn_pkg::TABLE_DW-1:0] mem [ogn_pkg::TABLE_DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports, registered
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

FILE: design/ogn_checker.sv
`default_nettype none
`include "octave_gradient_noise_2d_defines.svh"
module ogn_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic cmd,
	input wire logic done
);

	// A result only appears while an evaluation is in flight
	`OGN_ASSERT_SAME(a_done_busy, clk, arst_n, done, busy)

	// A result strobe lasts one cycle and ends the evaluation
	`OGN_ASSERT_NEXT(a_done_end, clk, arst_n, done, !done && !busy)

	// A table write transfer leaves the block free
	`OGN_ASSERT_NEXT(a_write_free, clk, arst_n, start && !busy && cmd == ogn_pkg::CMD_WRITE, !busy)

	// An evaluate transfer starts work with no immediate result
	`OGN_ASSERT_NEXT(a_eval_busy, clk, arst_n, start && !busy && cmd == ogn_pkg::CMD_EVAL, busy && !done)

endmodule

bind octave_gradient_noise_2d ogn_checker u_ogn_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done)
);
`default_nettype wire
